/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the source text tokenizer: beat formats,
// character classes, scanner modes and token class codes.
// ----------------------------------------------------------------------------
package stt_pkg;

   // sizing
   localparam int MAX_LEXEME   = 31;
   localparam int LINE_BITS    = 16;
   localparam int LEN_BITS     = 8;
   localparam int LEN_MAX      = 255;
   localparam int PREFIX_CHARS = 5;
   localparam int PREFIX_BITS  = 8 * PREFIX_CHARS;

   // item queue between front and scanner
   localparam int FQ_DEPTH = 2;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

   // result queue, power-of-two depth, takes up to two beats per cycle
   localparam int RQ_DEPTH = 4;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);
   localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

   // token classes
   localparam logic [4:0] TOK_IDENT        = 5'd0;
   localparam logic [4:0] TOK_KEYWORD      = 5'd1;
   localparam logic [4:0] TOK_NUMBER       = 5'd2;
   localparam logic [4:0] TOK_LPAREN       = 5'd3;
   localparam logic [4:0] TOK_SLASH        = 5'd11;
   localparam logic [4:0] TOK_ASSIGN       = 5'd12;
   localparam logic [4:0] TOK_EQUAL        = 5'd15;
   localparam logic [4:0] TOK_COMMENT      = 5'd19;
   localparam logic [4:0] TOK_BAD_CHAR     = 5'd20;
   localparam logic [4:0] TOK_LONE_BANG    = 5'd21;
   localparam logic [4:0] TOK_OPEN_COMMENT = 5'd22;

   // delimiter indexes, offset from TOK_LPAREN
   localparam logic [2:0] DL_LPAREN = 3'd0;
   localparam logic [2:0] DL_RPAREN = 3'd1;
   localparam logic [2:0] DL_LBRACE = 3'd2;
   localparam logic [2:0] DL_RBRACE = 3'd3;
   localparam logic [2:0] DL_SEMI   = 3'd4;
   localparam logic [2:0] DL_PLUS   = 3'd5;
   localparam logic [2:0] DL_MINUS  = 3'd6;
   localparam logic [2:0] DL_STAR   = 3'd7;

   // relational operator leads
   localparam logic [1:0] OP_EQ   = 2'd0;
   localparam logic [1:0] OP_LT   = 2'd1;
   localparam logic [1:0] OP_GT   = 2'd2;
   localparam logic [1:0] OP_BANG = 2'd3;

   // keyword indexes
   localparam logic [2:0] KW_IF    = 3'd0;
   localparam logic [2:0] KW_ELSE  = 3'd1;
   localparam logic [2:0] KW_FOR   = 3'd2;
   localparam logic [2:0] KW_WHILE = 3'd3;
   localparam logic [2:0] KW_DO    = 3'd4;
   localparam logic [2:0] KW_INT   = 3'd5;
   localparam logic [2:0] KW_WRITE = 3'd6;
   localparam logic [2:0] KW_READ  = 3'd7;

   typedef enum logic [2:0] {
      CC_ALPHA,
      CC_DIGIT,
      CC_SLASH,
      CC_DELIM,
      CC_RELOP,
      CC_SPACE,
      CC_NEWLINE,
      CC_BAD
   } char_class_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_SLASH,
      MODE_RELOP,
      MODE_COMMENT
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } stt_req_type;

   typedef struct packed {
      logic [4:0]  token_class;
      logic [2:0]  keyword_index;
      logic [15:0] line_number;
      logic [4:0]  lexeme_length;
      logic [7:0]  offending_char;
      logic        last_of_run;
   } stt_rsp_type;

   // classified character as it waits for the scanner
   typedef struct packed {
      logic           eoi;
      logic [7:0]     code;
      char_class_type cls;
      logic [2:0]     sub;
   } stt_item_type;

   // up to two result beats from one scanner step
   typedef struct packed {
      logic        v0;
      logic        v1;
      stt_rsp_type r0;
      stt_rsp_type r1;
   } stt_emit_type;

endpackage

/* src/source_text_tokenizer_core.sv */
// a character beat waits in the item queue, its result beats in the result queue
// throughput: one character beat per cycle while the result queue has room; one result
// beat per cycle on the single rsp port unless rsp_stall; two beats of a step go in turn
// reset: synchronous, clears both queues, scanner idle, line count back to one
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Lexical scanner for a small C-like language: characters in, tokens with
// class, keyword index, line and length out.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core (
   input  logic                 clock,
   input  logic                 reset,
   // character beats
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stt_pkg::stt_req_type req_beat,
   // token beats
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stt_pkg::stt_rsp_type rsp_beat
);

   // front to scanner
   logic                  item_valid;
   stt_pkg::stt_item_type item;
   logic                  item_pop;

   // scanner to result queue
   stt_pkg::stt_emit_type emit;
   logic                  room;

   // front: classify each character and park it in a two-entry queue;
   // req_stall only rises when that queue is full
   stt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // scanner: one character per cycle whenever the result queue has space
   // for two beats; a token ended by lookahead plus a token started by the
   // same character give the two-beat case
   stt_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .room       (room),
      .emit       (emit)
   );

   // result queue: decouples scanner from rsp_stall, head is the rsp beat
   stt_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

/* src/stt_front.sv */
// ----------------------------------------------------------------------------
// stt_front
// Accepts character beats, classifies them and holds them in a short queue
// for the scanner.
// ----------------------------------------------------------------------------
module stt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stt_pkg::stt_req_type req_beat,
   output logic                 item_valid,
   output stt_pkg::stt_item_type item,
   input  logic                 item_pop
);

   stt_pkg::stt_item_type fq_ff [stt_pkg::FQ_DEPTH];
   logic [stt_pkg::FQ_AW-1:0] wr_ff, wr_in;
   logic [stt_pkg::FQ_AW-1:0] rd_ff, rd_in;
   logic [stt_pkg::FQ_CW-1:0] cnt_ff, cnt_in;
   stt_pkg::stt_item_type     cls_item;
   logic                      push;

   // character classification
   always_comb begin
      cls_item.eoi  = req_beat.end_of_input;
      cls_item.code = req_beat.char_code;
      cls_item.cls  = stt_pkg::CC_BAD;
      cls_item.sub  = stt_pkg::DL_LPAREN;
      case (req_beat.char_code) inside
         ["a":"z"], ["A":"Z"]: cls_item.cls = stt_pkg::CC_ALPHA;
         ["0":"9"]:            cls_item.cls = stt_pkg::CC_DIGIT;
         "/":                  cls_item.cls = stt_pkg::CC_SLASH;
         "(": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_LPAREN; end
         ")": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_RPAREN; end
         "{": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_LBRACE; end
         "}": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_RBRACE; end
         ";": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_SEMI; end
         "+": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_PLUS; end
         "-": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_MINUS; end
         "*": begin cls_item.cls = stt_pkg::CC_DELIM; cls_item.sub = stt_pkg::DL_STAR; end
         "=": begin cls_item.cls = stt_pkg::CC_RELOP; cls_item.sub = {1'b0, stt_pkg::OP_EQ}; end
         "<": begin cls_item.cls = stt_pkg::CC_RELOP; cls_item.sub = {1'b0, stt_pkg::OP_LT}; end
         ">": begin cls_item.cls = stt_pkg::CC_RELOP; cls_item.sub = {1'b0, stt_pkg::OP_GT}; end
         "!": begin
            cls_item.cls = stt_pkg::CC_RELOP;
            cls_item.sub = {1'b0, stt_pkg::OP_BANG};
         end
         " ", 8'h09:           cls_item.cls = stt_pkg::CC_SPACE;
         8'h0a:                cls_item.cls = stt_pkg::CC_NEWLINE;
         default:              cls_item.cls = stt_pkg::CC_BAD;
      endcase
   end

   assign req_stall  = (cnt_ff == stt_pkg::FQ_CW'(stt_pkg::FQ_DEPTH));
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != '0);
   assign item       = fq_ff[rd_ff];

   always_comb begin
      wr_in  = push     ? stt_pkg::FQ_AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = item_pop ? stt_pkg::FQ_AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = stt_pkg::FQ_CW'(cnt_ff + stt_pkg::FQ_CW'(push) - stt_pkg::FQ_CW'(item_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[wr_ff] <= cls_item;
      end
   end

endmodule

/* src/stt_scan.sv */
// ----------------------------------------------------------------------------
// stt_scan
// Token scanner: one classified character per step, up to two result beats.
// ----------------------------------------------------------------------------
module stt_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  stt_pkg::stt_item_type item,
   output logic                  item_pop,
   input  logic                  room,
   output stt_pkg::stt_emit_type emit
);

   stt_pkg::scan_mode_type mode_ff, mode_in;
   logic [stt_pkg::PREFIX_BITS-1:0] prefix_ff, prefix_in;
   logic [stt_pkg::LEN_BITS-1:0]    len_ff, len_in, len_bump;
   logic [stt_pkg::LINE_BITS-1:0]   line_ff, line_in, line_bump;
   logic [1:0]                      op_ff, op_in;
   logic                            star_ff, star_in;

   logic go, eoi, is_alnum, is_digit, is_zero, is_eq, is_star, is_slash, is_nl;
   logic consumed, restart, close_comment;
   logic flush_v, start_v;
   stt_pkg::stt_rsp_type flush_r, start_r, base_r;
   logic [3:0] kw_hit;

   function automatic logic [stt_pkg::PREFIX_BITS-1:0] kw_text(input logic [2:0] k);
      logic [stt_pkg::PREFIX_BITS-1:0] t;
      case (k)
         stt_pkg::KW_IF:    t = {24'h0, "f", "i"};
         stt_pkg::KW_ELSE:  t = {8'h0, "e", "s", "l", "e"};
         stt_pkg::KW_FOR:   t = {16'h0, "r", "o", "f"};
         stt_pkg::KW_WHILE: t = {"e", "l", "i", "h", "w"};
         stt_pkg::KW_DO:    t = {24'h0, "o", "d"};
         stt_pkg::KW_INT:   t = {16'h0, "t", "n", "i"};
         stt_pkg::KW_WRITE: t = {"e", "t", "i", "r", "w"};
         stt_pkg::KW_READ:  t = {8'h0, "d", "a", "e", "r"};
         default:           t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [stt_pkg::LEN_BITS-1:0] kw_len(input logic [2:0] k);
      logic [stt_pkg::LEN_BITS-1:0] n;
      case (k)
         stt_pkg::KW_IF, stt_pkg::KW_DO:                   n = 8'd2;
         stt_pkg::KW_FOR, stt_pkg::KW_INT:                 n = 8'd3;
         stt_pkg::KW_ELSE, stt_pkg::KW_READ:               n = 8'd4;
         stt_pkg::KW_WHILE, stt_pkg::KW_WRITE:             n = 8'd5;
         default:                                          n = '0;
      endcase
      return n;
   endfunction

   // {hit, index}; bytes past the length are always zero in the prefix
   function automatic logic [3:0] kw_find(input logic [stt_pkg::PREFIX_BITS-1:0] p,
                                          input logic [stt_pkg::LEN_BITS-1:0] n);
      logic       hit;
      logic [2:0] idx;
      hit = 1'b0;
      idx = '0;
      for (int k = 0; k < 8; k++) begin
         if (!hit && p == kw_text(3'(k)) && n == kw_len(3'(k))) begin
            hit = 1'b1;
            idx = 3'(k);
         end
      end
      return {hit, idx};
   endfunction

   function automatic logic [4:0] shown(input logic [stt_pkg::LEN_BITS-1:0] n);
      return (n > stt_pkg::LEN_BITS'(stt_pkg::MAX_LEXEME)) ? 5'(stt_pkg::MAX_LEXEME) : 5'(n);
   endfunction

   assign go       = item_valid && room;
   assign item_pop = go;
   assign eoi      = item.eoi;
   assign is_digit = (item.cls == stt_pkg::CC_DIGIT);
   assign is_alnum = (item.cls == stt_pkg::CC_ALPHA) || is_digit;
   assign is_zero  = is_digit && (item.code == "0");
   assign is_eq    = (item.cls == stt_pkg::CC_RELOP) && (item.sub[1:0] == stt_pkg::OP_EQ);
   assign is_star  = (item.cls == stt_pkg::CC_DELIM) && (item.sub == stt_pkg::DL_STAR);
   assign is_slash = (item.cls == stt_pkg::CC_SLASH);
   assign is_nl    = (item.cls == stt_pkg::CC_NEWLINE);

   assign len_bump  = (len_ff == stt_pkg::LEN_BITS'(stt_pkg::LEN_MAX)) ?
                      len_ff : stt_pkg::LEN_BITS'(len_ff + 1'b1);
   assign line_bump = (line_ff == '1) ? line_ff : stt_pkg::LINE_BITS'(line_ff + 1'b1);
   assign kw_hit    = kw_find(prefix_ff, len_ff);

   // does the current mode take this character
   always_comb begin
      case (mode_ff)
         stt_pkg::MODE_IDENT:   consumed = !eoi && is_alnum;
         stt_pkg::MODE_NUMBER:  consumed = !eoi && is_digit;
         stt_pkg::MODE_SLASH:   consumed = !eoi && is_star;
         stt_pkg::MODE_RELOP:   consumed = !eoi && is_eq;
         stt_pkg::MODE_COMMENT: consumed = !eoi;
         default:               consumed = 1'b0;
      endcase
      restart       = !eoi && !consumed;
      close_comment = (mode_ff == stt_pkg::MODE_COMMENT) && !eoi && !is_nl &&
                      star_ff && is_slash;
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (eoi) begin
         mode_in = stt_pkg::MODE_IDLE;
      end else if (restart) begin
         case (item.cls)
            stt_pkg::CC_ALPHA: mode_in = stt_pkg::MODE_IDENT;
            stt_pkg::CC_DIGIT: mode_in = is_zero ? stt_pkg::MODE_IDLE : stt_pkg::MODE_NUMBER;
            stt_pkg::CC_SLASH: mode_in = stt_pkg::MODE_SLASH;
            stt_pkg::CC_RELOP: mode_in = stt_pkg::MODE_RELOP;
            default:           mode_in = stt_pkg::MODE_IDLE;
         endcase
      end else begin
         case (mode_ff)
            stt_pkg::MODE_SLASH: mode_in = stt_pkg::MODE_COMMENT;
            stt_pkg::MODE_RELOP: mode_in = stt_pkg::MODE_IDLE;
            stt_pkg::MODE_COMMENT: begin
               mode_in = (is_nl || close_comment) ? stt_pkg::MODE_IDLE : stt_pkg::MODE_COMMENT;
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // token text, length, line and lookahead state
   always_comb begin
      prefix_in = prefix_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      op_in     = op_ff;
      star_in   = star_ff;
      if (eoi) begin
         prefix_in = '0;
         len_in    = '0;
         line_in   = stt_pkg::LINE_BITS'(1);
         op_in     = '0;
         star_in   = 1'b0;
      end else begin
         if (restart) begin
            prefix_in = '0;
            len_in    = '0;
            star_in   = 1'b0;
            case (item.cls)
               stt_pkg::CC_ALPHA: begin
                  prefix_in = stt_pkg::PREFIX_BITS'(item.code);
                  len_in    = stt_pkg::LEN_BITS'(1);
               end
               stt_pkg::CC_DIGIT:   len_in  = is_zero ? '0 : stt_pkg::LEN_BITS'(1);
               stt_pkg::CC_RELOP:   op_in   = item.sub[1:0];
               stt_pkg::CC_NEWLINE: line_in = line_bump;
               default:             ;
            endcase
         end else begin
            case (mode_ff)
               stt_pkg::MODE_IDENT: begin
                  for (int i = 0; i < stt_pkg::PREFIX_CHARS; i++) begin
                     if (len_ff == stt_pkg::LEN_BITS'(i)) begin
                        prefix_in[8*i +: 8] = item.code;
                     end
                  end
                  len_in = len_bump;
               end
               stt_pkg::MODE_NUMBER: len_in = len_bump;
               stt_pkg::MODE_SLASH: begin
                  len_in  = stt_pkg::LEN_BITS'(2);
                  star_in = 1'b0;
               end
               stt_pkg::MODE_COMMENT: begin
                  if (is_nl) begin
                     line_in = line_bump;
                  end else begin
                     len_in  = len_bump;
                     star_in = is_star;
                  end
               end
               default: ;
            endcase
         end
         if (mode_in == stt_pkg::MODE_IDLE) begin
            prefix_in = '0;
            op_in     = '0;
            star_in   = 1'b0;
         end
      end
   end

   // result beats
   always_comb begin
      base_r                = '0;
      base_r.line_number    = 16'(line_ff);
      base_r.lexeme_length  = 5'd1;
      flush_v               = 1'b0;
      flush_r               = base_r;
      start_v               = 1'b0;
      start_r               = base_r;

      case (mode_ff)
         stt_pkg::MODE_IDENT: begin
            flush_v               = !consumed;
            flush_r.token_class   = kw_hit[3] ? stt_pkg::TOK_KEYWORD : stt_pkg::TOK_IDENT;
            flush_r.keyword_index = kw_hit[3] ? kw_hit[2:0] : 3'd0;
            flush_r.lexeme_length = shown(len_ff);
         end
         stt_pkg::MODE_NUMBER: begin
            flush_v               = !consumed;
            flush_r.token_class   = stt_pkg::TOK_NUMBER;
            flush_r.lexeme_length = shown(len_ff);
         end
         stt_pkg::MODE_SLASH: begin
            flush_v             = !consumed;
            flush_r.token_class = stt_pkg::TOK_SLASH;
         end
         stt_pkg::MODE_RELOP: begin
            flush_v = 1'b1;
            if (consumed) begin
               flush_r.token_class   = 5'(stt_pkg::TOK_EQUAL + 5'(op_ff));
               flush_r.lexeme_length = 5'd2;
            end else if (op_ff == stt_pkg::OP_BANG) begin
               flush_r.token_class = stt_pkg::TOK_LONE_BANG;
            end else begin
               flush_r.token_class = 5'(stt_pkg::TOK_ASSIGN + 5'(op_ff));
            end
         end
         stt_pkg::MODE_COMMENT: begin
            if (eoi || is_nl) begin
               flush_v               = 1'b1;
               flush_r.token_class   = stt_pkg::TOK_OPEN_COMMENT;
               flush_r.lexeme_length = shown(len_ff);
            end else if (close_comment) begin
               flush_v               = 1'b1;
               flush_r.token_class   = stt_pkg::TOK_COMMENT;
               flush_r.lexeme_length = shown(len_bump);
            end
         end
         default: ;
      endcase

      if (restart) begin
         case (item.cls)
            stt_pkg::CC_DIGIT: begin
               start_v             = is_zero;
               start_r.token_class = stt_pkg::TOK_NUMBER;
            end
            stt_pkg::CC_DELIM: begin
               start_v             = 1'b1;
               start_r.token_class = 5'(stt_pkg::TOK_LPAREN + 5'(item.sub));
            end
            stt_pkg::CC_BAD: begin
               start_v                = 1'b1;
               start_r.token_class    = stt_pkg::TOK_BAD_CHAR;
               start_r.offending_char = item.code;
            end
            default: ;
         endcase
      end

      emit.v0             = go && (flush_v || start_v);
      emit.v1             = go && flush_v && start_v;
      emit.r0             = flush_v ? flush_r : start_r;
      emit.r0.last_of_run = !(flush_v && start_v);
      emit.r1             = start_r;
      emit.r1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stt_pkg::MODE_IDLE;
         prefix_ff <= '0;
         len_ff    <= '0;
         line_ff   <= stt_pkg::LINE_BITS'(1);
         op_ff     <= '0;
         star_ff   <= 1'b0;
      end else if (go) begin
         mode_ff   <= mode_in;
         prefix_ff <= prefix_in;
         len_ff    <= len_in;
         line_ff   <= line_in;
         op_ff     <= op_in;
         star_ff   <= star_in;
      end
   end

endmodule

/* src/stt_rspq.sv */
// ----------------------------------------------------------------------------
// stt_rspq
// Result queue: takes up to two beats per cycle from the scanner, hands one
// beat per cycle to the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module stt_rspq (
   input  logic                  clock,
   input  logic                  reset,
   input  stt_pkg::stt_emit_type emit,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stt_pkg::stt_rsp_type  rsp_beat
);

   stt_pkg::stt_rsp_type      rq_ff [stt_pkg::RQ_DEPTH];
   logic [stt_pkg::RQ_AW-1:0] wr_ff, wr_in, wr_next;
   logic [stt_pkg::RQ_AW-1:0] rd_ff, rd_in;
   logic [stt_pkg::RQ_CW-1:0] cnt_ff, cnt_in;
   logic                      pop;

   // room for a two-beat step regardless of this cycle's pop
   assign room      = (cnt_ff <= stt_pkg::RQ_CW'(stt_pkg::RQ_DEPTH - 2));
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_beat  = rq_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = stt_pkg::RQ_AW'(wr_ff + 1'b1);

   always_comb begin
      wr_in  = stt_pkg::RQ_AW'(wr_ff + stt_pkg::RQ_AW'(emit.v0) + stt_pkg::RQ_AW'(emit.v1));
      rd_in  = pop ? stt_pkg::RQ_AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = stt_pkg::RQ_CW'(cnt_ff + stt_pkg::RQ_CW'(emit.v0) + stt_pkg::RQ_CW'(emit.v1)
                               - stt_pkg::RQ_CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.v0) begin
         rq_ff[wr_ff] <= emit.r0;
      end
      if (emit.v1) begin
         rq_ff[wr_next] <= emit.r1;
      end
   end

endmodule

/* src/stt_checker.sv */
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer core, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input stt_pkg::stt_rsp_type rsp_beat
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat withdrawn under stall");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_beat))
      else $error("rsp payload changed under stall");

   // keyword index only on keyword tokens, offending char only on bad chars
   a_side_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_beat.token_class == stt_pkg::TOK_KEYWORD || rsp_beat.keyword_index == 3'd0) &&
         (rsp_beat.token_class == stt_pkg::TOK_BAD_CHAR || rsp_beat.offending_char == 8'd0))
      else $error("side field set on wrong token class");

   // class in range, length and line never zero
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beat.token_class <= stt_pkg::TOK_OPEN_COMMENT &&
                    rsp_beat.lexeme_length != 5'd0 && rsp_beat.line_number != 16'd0)
      else $error("token fields out of range");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);
